@@ src/pjq_pkg.sv @@
// Package with shared types, codes and constants of the priority job queue.
`timescale 1ns / 1ps

package pjq_pkg;

    // Default number of queue entries.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Reset value of the speed multiplier, 1.0 in unsigned Q4.4.
    localparam logic [7:0] SPEED_RESET = 8'd16;

    // Largest elapsed time that the head timer can hold.
    localparam logic [23:0] ELAPSED_MAX = 24'hFFFFFF;

    // Action codes of an input item.
    localparam logic [2:0] ACT_ADD   = 3'd0;
    localparam logic [2:0] ACT_REM   = 3'd1;
    localparam logic [2:0] ACT_CLEAR = 3'd2;
    localparam logic [2:0] ACT_PRIO  = 3'd3;
    localparam logic [2:0] ACT_PAUSE = 3'd4;
    localparam logic [2:0] ACT_TICK  = 3'd5;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_IDX  = 2'd2;

    // Register indexes of the configuration port.
    localparam logic REG_SPEED = 1'b0;

    // One command transfer.
    typedef struct packed {
        logic [2:0]         action;
        logic [15:0]        unit_id;
        logic [15:0]        build_time;
        logic signed [7:0]  new_priority;
        logic [3:0]         entry_index;
        logic               pause_flag;
        logic [7:0]         elapsed_ticks;
    } t_in_item;

    // One result transfer.
    typedef struct packed {
        logic               done_res;
        logic [15:0]        done_unit;
        logic [4:0]         job_count;
        logic [1:0]         status;
        logic [15:0]        head_unit;
        logic [23:0]        head_elapsed;
    } t_out_item;

    // One stored job.
    typedef struct packed {
        logic [15:0]        id;
        logic [15:0]        btime;
        logic signed [7:0]  prio;
        logic [23:0]        elapsed;
    } t_entry;

endpackage

@@ src/priority_job_queue_with_head_timer_unit.sv @@
// Top level of the priority job queue with its head timer.
`timescale 1ns / 1ps

// The queue keeps up to QUEUE_DEPTH jobs in one table with one read and one write
// port, sorted by descending priority with arrival order kept among equal
// priorities. Every command is taken only while o_in_stall is low and is then
// worked on alone. Each move of a job by one entry is a table read, then a compare
// and a write through the one shared priority comparator. A tick on a running,
// non-empty queue reads the head job, multiplies the command's elapsed ticks by
// the speed, adds the product to the head timer with saturation, and a finished
// head job then leaves the queue; clear, pause, unused actions and refused
// commands go straight to the result. The result sits in an output register,
// and the next command may be taken while it waits there; a new result waits
// in the last step for as long as the previous one is stalled. Speed is written
// through the APB port at byte address 0.
module priority_job_queue_with_head_timer_unit #(
    parameter int QUEUE_DEPTH = pjq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Command channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pjq_pkg::t_in_item   i_in,
    // Result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pjq_pkg::t_out_item  o_out,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = ((OW > 4) ? OW : 4) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GET,
        S_GET_CHK,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_TK_RD,
        S_TK_MUL,
        S_TK_ADD,
        S_HEAD,
        S_OUT
    } t_state;

    t_state               r_state, n_state;
    logic [OW-1:0]        r_occ, n_occ;
    logic                 r_paused, n_paused;
    logic [7:0]           r_speed;
    logic [AW-1:0]        r_pos, n_pos;
    pjq_pkg::t_entry      r_hold, n_hold;
    pjq_pkg::t_in_item    r_cmd, n_cmd;
    logic [1:0]           r_status, n_status;
    logic                 r_done, n_done;
    logic [15:0]          r_done_unit, n_done_unit;
    logic                 r_drop, n_drop;
    logic [15:0]          r_prod, n_prod;
    logic                 r_out_valid, n_out_valid;
    pjq_pkg::t_out_item   r_out, n_out;

    // Job table and its registered read port.
    pjq_pkg::t_entry      r_mem [QUEUE_DEPTH];
    pjq_pkg::t_entry      r_rd_data;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    pjq_pkg::t_entry      mem_wdata;

    // Shared priority comparator.
    logic signed [7:0]    cmp_a, cmp_b;
    logic                 cmp_gt;

    logic                 in_xfer;
    logic                 cfg_wr;
    logic [CW-1:0]        idx_ext;
    logic                 idx_bad;
    logic                 more_after;
    logic [24:0]          tick_sum;
    logic [23:0]          tick_sat;
    logic                 tick_done;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out      = r_out;

    // Configuration port: always ready, one register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == pjq_pkg::REG_SPEED);
    assign prdata = (paddr[2] == pjq_pkg::REG_SPEED) ? {24'd0, r_speed} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= pjq_pkg::SPEED_RESET;
        end else if (cfg_wr) begin
            r_speed <= pwdata[7:0];
        end
    end

    // Index range check against the current occupancy.
    assign idx_ext    = CW'(i_in.entry_index);
    assign idx_bad    = idx_ext >= CW'(r_occ);
    assign more_after = (CW'(r_pos) + CW'(1)) < CW'(r_occ);

    // The comparator operands follow the step in progress.
    always_comb begin
        cmp_a = r_rd_data.prio;
        cmp_b = r_hold.prio;
        unique case (r_state)
            S_UP_WR: begin
                cmp_a = r_hold.prio;
                cmp_b = r_rd_data.prio;
            end
            S_GET_CHK: begin
                cmp_a = r_cmd.new_priority;
                cmp_b = r_rd_data.prio;
            end
            default: begin
                cmp_a = r_rd_data.prio;
                cmp_b = r_hold.prio;
            end
        endcase
    end
    assign cmp_gt = cmp_a > cmp_b;

    // Head timer arithmetic: saturating add of the registered product.
    assign tick_sum  = 25'(r_hold.elapsed) + 25'(r_prod);
    assign tick_sat  = tick_sum[24] ? pjq_pkg::ELAPSED_MAX : tick_sum[23:0];
    assign tick_done = tick_sat >= 24'({r_hold.btime, 4'd0});

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_paused    = r_paused;
        n_pos       = r_pos;
        n_hold      = r_hold;
        n_cmd       = r_cmd;
        n_status    = r_status;
        n_done      = r_done;
        n_done_unit = r_done_unit;
        n_drop      = r_drop;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        rd_addr     = r_pos;
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_hold;

        // The result leaves once the far side takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd       = i_in;
                    n_status    = pjq_pkg::ST_OK;
                    n_done      = 1'b0;
                    n_done_unit = 16'd0;
                    n_drop      = 1'b0;
                    n_state     = S_HEAD;
                    unique case (i_in.action)
                        pjq_pkg::ACT_ADD: begin
                            if (r_occ >= OW'(QUEUE_DEPTH)) begin
                                n_status = pjq_pkg::ST_FULL;
                            end else begin
                                n_hold.id      = i_in.unit_id;
                                n_hold.btime   = i_in.build_time;
                                n_hold.prio    = i_in.new_priority;
                                n_hold.elapsed = 24'd0;
                                n_pos          = r_occ[AW-1:0];
                                n_occ          = r_occ + OW'(1);
                                n_state        = S_UP_RD;
                            end
                        end
                        pjq_pkg::ACT_REM: begin
                            if (idx_bad) begin
                                n_status = pjq_pkg::ST_BAD_IDX;
                            end else begin
                                n_pos   = idx_ext[AW-1:0];
                                n_drop  = 1'b1;
                                n_state = S_DN_RD;
                            end
                        end
                        pjq_pkg::ACT_CLEAR: begin
                            n_occ = '0;
                        end
                        pjq_pkg::ACT_PRIO: begin
                            if (idx_bad) begin
                                n_status = pjq_pkg::ST_BAD_IDX;
                            end else begin
                                n_pos   = idx_ext[AW-1:0];
                                n_state = S_GET;
                            end
                        end
                        pjq_pkg::ACT_PAUSE: begin
                            n_paused = i_in.pause_flag;
                        end
                        pjq_pkg::ACT_TICK: begin
                            if (!r_paused && (r_occ != '0)) begin
                                n_state = S_TK_RD;
                            end
                        end
                        default: begin
                            n_state = S_HEAD;
                        end
                    endcase
                end
            end

            // Fetch the job whose priority changes.
            S_GET: begin
                rd_addr = r_pos;
                n_state = S_GET_CHK;
            end

            // A raised priority moves towards the head, otherwise towards the tail.
            S_GET_CHK: begin
                n_hold      = r_rd_data;
                n_hold.prio = r_cmd.new_priority;
                n_state     = cmp_gt ? S_UP_RD : S_DN_RD;
            end

            S_UP_RD: begin
                rd_addr = r_pos - AW'(1);
                n_state = S_UP_WR;
            end

            // Shift the lower-priority neighbour back, or drop the held job in.
            S_UP_WR: begin
                mem_we = 1'b1;
                if ((r_pos != '0) && cmp_gt) begin
                    mem_wdata = r_rd_data;
                    n_pos     = r_pos - AW'(1);
                    n_state   = S_UP_RD;
                end else begin
                    mem_wdata = r_hold;
                    n_state   = S_HEAD;
                end
            end

            S_DN_RD: begin
                rd_addr = r_pos + AW'(1);
                n_state = S_DN_WR;
            end

            // Pull the next job forward; a removal pulls all of them.
            S_DN_WR: begin
                if (more_after && (r_drop || cmp_gt)) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rd_data;
                    n_pos     = r_pos + AW'(1);
                    n_state   = S_DN_RD;
                end else begin
                    if (r_drop) begin
                        n_occ = r_occ - OW'(1);
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = r_hold;
                    end
                    n_state = S_HEAD;
                end
            end

            S_TK_RD: begin
                rd_addr = '0;
                n_state = S_TK_MUL;
            end

            S_TK_MUL: begin
                n_hold  = r_rd_data;
                n_prod  = 16'(r_cmd.elapsed_ticks) * 16'(r_speed);
                n_state = S_TK_ADD;
            end

            // Advance the head job; a finished job is removed from the head.
            S_TK_ADD: begin
                if (tick_done) begin
                    n_done      = 1'b1;
                    n_done_unit = r_hold.id;
                    n_drop      = 1'b1;
                    n_pos       = '0;
                    n_state     = S_DN_RD;
                end else begin
                    mem_we            = 1'b1;
                    mem_waddr         = '0;
                    mem_wdata         = r_hold;
                    mem_wdata.elapsed = tick_sat;
                    n_state           = S_HEAD;
                end
            end

            S_HEAD: begin
                rd_addr = '0;
                n_state = S_OUT;
            end

            // Hand the result over once the output register is free.
            S_OUT: begin
                rd_addr = '0;
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid            = 1'b1;
                    n_out.done_res         = r_done;
                    n_out.done_unit        = r_done_unit;
                    n_out.job_count        = 5'(r_occ);
                    n_out.status           = r_status;
                    n_out.head_unit        = (r_occ != '0) ? r_rd_data.id : 16'd0;
                    n_out.head_elapsed     = (r_occ != '0) ? r_rd_data.elapsed : 24'd0;
                    n_state                = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_paused    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_paused    <= n_paused;
            r_out_valid <= n_out_valid;
        end
        r_pos       <= n_pos;
        r_hold      <= n_hold;
        r_cmd       <= n_cmd;
        r_status    <= n_status;
        r_done      <= n_done;
        r_done_unit <= n_done_unit;
        r_drop      <= n_drop;
        r_prod      <= n_prod;
        r_out       <= n_out;
    end

    // Job table.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // A command transfer closes the command channel until its result is formed.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("command channel open while a command is in progress");

    // The queue never holds more jobs than it has entries.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    // The head timer only runs while the queue is running and not empty.
    a_tick_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TK_MUL) |-> (!r_paused && (r_occ != '0)))
        else $error("head timer advanced while paused or empty");

    // A finished job is only reported together with an ok status.
    a_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_done) |-> (r_status == pjq_pkg::ST_OK))
        else $error("finished job reported with an error status");

endmodule
